// File: sv/tbcl_pkg.sv
// Package for the two-button combination lock.
// Holds sizes, mode and register codes, and the result record type.
// No dependencies.
`default_nettype none

package tbcl_pkg;

  localparam int CODE_BITS        = 6;
  localparam int DEBOUNCE_SAMPLES = 6;
  localparam int CNT_W            = $clog2(CODE_BITS + 1);
  localparam int HALF_W           = 8;
  localparam int TOG_W            = 4;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 8;

  localparam logic [1:0] MODE_PROG   = 2'd0;
  localparam logic [1:0] MODE_LOCKED = 2'd1;
  localparam logic [1:0] MODE_BLINK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TOGGLE_COUNT = 1'd1;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RST  = 8'd144;
  localparam logic [TOG_W-1:0]  TOGGLE_COUNT_RST = 4'd10;

  typedef struct packed {
    logic [1:0]       lock_mode;
    logic             key_held;
    logic             yellow_level;
    logic [CNT_W-1:0] bits_entered;
    logic             unlock_pulse;
    logic             fail_pulse;
  } tbcl_result_t;

endpackage

`default_nettype wire

// File: sv/tbcl_debounce.sv
// Shift-history debouncer for one button.
// Depends on tbcl_pkg for the history length.
`default_nettype none

module tbcl_debounce
  import tbcl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic clr_i,
  input  wire logic sample_i,
  output logic      pressed_d_o,
  output logic      release_o
);

  logic [DEBOUNCE_SAMPLES-1:0] hist_q, hist_d;
  logic                        pressed_q;

  assign hist_d      = {hist_q[DEBOUNCE_SAMPLES-2:0], sample_i};
  assign pressed_d_o = (&hist_d) ? 1'b1 : ((~|hist_d) ? 1'b0 : pressed_q);
  assign release_o   = pressed_q & ~pressed_d_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      pressed_q <= 1'b0;
    end else if (clr_i) begin
      hist_q    <= '0;
      pressed_q <= 1'b0;
    end else if (en_i) begin
      hist_q    <= hist_d;
      pressed_q <= pressed_d_o;
    end
  end

endmodule

`default_nettype wire

// File: sv/tbcl_core.sv
// Lock state and per-sample update: code entry, compare, blink timing.
// Depends on tbcl_pkg and tbcl_debounce.
`default_nettype none

module tbcl_core
  import tbcl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              key_zero_i,
  input  wire logic              key_one_i,
  input  wire logic [HALF_W-1:0] half_period_i,
  input  wire logic [TOG_W-1:0]  toggle_count_i,
  output tbcl_result_t           result_o
);

  logic [1:0]           mode_q, mode_d;
  logic                 last_q, last_d;
  logic [CODE_BITS-1:0] entry_q, entry_d, stored_q, stored_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [HALF_W-1:0]    timer_q, timer_d, timer_inc;
  logic [TOG_W-1:0]     done_q, done_d, done_inc;
  logic                 yellow_q, yellow_d;
  logic                 change;
  logic                 unlock, fail;
  logic                 dbc_en;
  logic                 pz_d, po_d, rel_z, rel_o;
  logic [CODE_BITS-1:0] entry_new;
  logic [CNT_W-1:0]     count_new;

  assign dbc_en = step_i && (mode_q != MODE_BLINK);

  tbcl_debounce u_dbc_zero (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (dbc_en),
    .clr_i      (step_i && change),
    .sample_i   (key_zero_i),
    .pressed_d_o(pz_d),
    .release_o  (rel_z)
  );

  tbcl_debounce u_dbc_one (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (dbc_en),
    .clr_i      (step_i && change),
    .sample_i   (key_one_i),
    .pressed_d_o(po_d),
    .release_o  (rel_o)
  );

  assign timer_inc = timer_q + 1'b1;
  assign done_inc  = done_q + 1'b1;

  always_comb begin
    mode_d    = mode_q;
    last_d    = last_q;
    entry_d   = entry_q;
    count_d   = count_q;
    stored_d  = stored_q;
    timer_d   = timer_q;
    done_d    = done_q;
    yellow_d  = yellow_q;
    change    = 1'b0;
    unlock    = 1'b0;
    fail      = 1'b0;
    entry_new = entry_q;
    count_new = count_q;
    case (mode_q)
      MODE_BLINK: begin
        timer_d = timer_inc;
        if (timer_inc == half_period_i) begin
          timer_d  = '0;
          yellow_d = ~yellow_q;
          done_d   = done_inc;
          if (done_inc == toggle_count_i) begin
            yellow_d = 1'b0;
            mode_d   = MODE_LOCKED;
            change   = 1'b1;
          end
        end
      end
      default: begin
        if (key_zero_i) begin
          last_d = 1'b0;
        end
        if (key_one_i) begin
          last_d = 1'b1;
        end
        if (rel_z || rel_o) begin
          entry_new = {entry_q[CODE_BITS-2:0], last_d};
          count_new = count_q + 1'b1;
        end
        entry_d = entry_new;
        count_d = count_new;
        if (count_new >= CNT_W'(CODE_BITS)) begin
          change = 1'b1;
          if (mode_q == MODE_PROG) begin
            stored_d = entry_new;
            mode_d   = MODE_LOCKED;
          end else if (entry_new == stored_q) begin
            unlock = 1'b1;
            mode_d = MODE_PROG;
          end else begin
            fail     = 1'b1;
            timer_d  = '0;
            done_d   = '0;
            yellow_d = 1'b1;
            mode_d   = MODE_BLINK;
          end
        end
      end
    endcase
    if (change) begin
      last_d  = 1'b0;
      entry_d = '0;
      count_d = '0;
    end
  end

  always_comb begin
    result_o.lock_mode    = mode_d;
    result_o.key_held     = change ? 1'b0 : (dbc_en && (pz_d || po_d));
    result_o.yellow_level = (mode_d == MODE_BLINK) ? yellow_d : 1'b0;
    result_o.bits_entered = count_d;
    result_o.unlock_pulse = unlock;
    result_o.fail_pulse   = fail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PROG;
      last_q   <= 1'b0;
      entry_q  <= '0;
      count_q  <= '0;
      stored_q <= '0;
      timer_q  <= '0;
      done_q   <= '0;
      yellow_q <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      last_q   <= last_d;
      entry_q  <= entry_d;
      count_q  <= count_d;
      stored_q <= stored_d;
      timer_q  <= timer_d;
      done_q   <= done_d;
      yellow_q <= yellow_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/two_button_combination_lock.sv
// Top level of the two-button combination lock: input register, lock core,
// result register, configuration registers. Depends on tbcl_pkg, tbcl_core.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | key_zero_level_i, key_one_level_i
//   out     | out_valid_o/out_stall_i | lock_mode_o .. fail_pulse_o
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One sample per cycle while the input is not stalled. A sample is held in the input
// register, and its result is loaded into the result register when the sample steps the core.
// The lock state updates as the result is loaded, in a single pass.
// Reset puts the lock in programming mode, registers at 144 and 10.
// A stall on the output holds the result; the input stalls only while the
// input register is full and the result register cannot drain.
`default_nettype none

module two_button_combination_lock
  import tbcl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  key_zero_level_i,
  input  wire logic                  key_one_level_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 lock_mode_o,
  output logic                       key_held_o,
  output logic                       yellow_level_o,
  output logic [CNT_W-1:0]           bits_entered_o,
  output logic                       unlock_pulse_o,
  output logic                       fail_pulse_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic              in_vld_q;
  logic              k0_q, k1_q;
  logic              out_vld_q;
  tbcl_result_t      res_q, res_d;
  logic [HALF_W-1:0] half_q;
  logic [TOG_W-1:0]  tog_q;
  logic              out_ready, step, in_xfer;

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      k0_q <= key_zero_level_i;
      k1_q <= key_one_level_i;
    end
  end

  tbcl_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .key_zero_i    (k0_q),
    .key_one_i     (k1_q),
    .half_period_i (half_q),
    .toggle_count_i(tog_q),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_PERIOD_RST;
      tog_q  <= TOGGLE_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BLINK_HALF_PERIOD:  half_q <= cfg_data_i[HALF_W-1:0];
        CFG_BLINK_TOGGLE_COUNT: tog_q  <= cfg_data_i[TOG_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_vld_q;
  assign lock_mode_o    = res_q.lock_mode;
  assign key_held_o     = res_q.key_held;
  assign yellow_level_o = res_q.yellow_level;
  assign bits_entered_o = res_q.bits_entered;
  assign unlock_pulse_o = res_q.unlock_pulse;
  assign fail_pulse_o   = res_q.fail_pulse;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register can drain");

  a_unlock_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unlock_pulse_o) |->
      (lock_mode_o == MODE_PROG && bits_entered_o == '0 && !fail_pulse_o))
    else $error("unlock result not in programming mode");

  a_fail_blink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fail_pulse_o) |->
      (lock_mode_o == MODE_BLINK && yellow_level_o && !key_held_o))
    else $error("fail result not entering blink with yellow on");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(lock_mode_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for two_button_combination_lock: a scripted opener,
// then randomized code entry under several blink settings, idling and back-pressure.
// Depends on tbcl_pkg and the two_button_combination_lock RTL.
module testbench;
  import tbcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int HOLD_CYCLES    = 60;
  localparam int N_PHASES       = 4;
  localparam int UNLOCK_PHASE   = 2;
  localparam int PHASE_LIVE_CAP = 400;

  localparam logic [CFG_DATA_W-1:0] PHASE_HALF [N_PHASES] =
    '{8'd144, 8'd1, 8'd0, 8'd6};
  localparam logic [CFG_DATA_W-1:0] PHASE_TOGGLE [N_PHASES] =
    '{8'h01, 8'h00, 8'h01, 8'hF3};

  typedef struct packed {
    logic         k0;
    logic         k1;
    logic [3:0]   reps;
    logic         typed;
    tbcl_result_t want;
  } key_row_t;

  // Press and release one key, then press and release both on the same tick.
  localparam key_row_t KEY_SCRIPT [7] = '{
    '{1'b0, 1'b0, 4'd1, 1'b1, '{MODE_PROG, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 4'd5, 1'b0, '{MODE_PROG, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 4'd1, 1'b1, '{MODE_PROG, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 4'd5, 1'b0, '{MODE_PROG, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 4'd1, 1'b1, '{MODE_PROG, 1'b0, 1'b0, 3'd1, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 4'd6, 1'b1, '{MODE_PROG, 1'b1, 1'b0, 3'd1, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 4'd6, 1'b1, '{MODE_PROG, 1'b0, 1'b0, 3'd2, 1'b0, 1'b0}}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  key_zero_level_i;
  logic                  key_one_level_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            lock_mode_o;
  logic                  key_held_o;
  logic                  yellow_level_o;
  logic [CNT_W-1:0]      bits_entered_o;
  logic                  unlock_pulse_o;
  logic                  fail_pulse_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Lock predictor state
  logic [DEBOUNCE_SAMPLES-1:0] zero_shift;
  logic [DEBOUNCE_SAMPLES-1:0] one_shift;
  logic                        zero_down;
  logic                        one_down;
  logic                        recent_key;
  logic [1:0]                  cur_mode;
  logic [CODE_BITS-1:0]        code_sr;
  logic [CNT_W-1:0]            code_len;
  logic [CODE_BITS-1:0]        saved_code;
  logic [HALF_W-1:0]           flash_timer;
  logic [TOG_W-1:0]            flash_count;
  logic                        amber;
  logic [HALF_W-1:0]           half_period;
  logic [TOG_W-1:0]            toggle_target;

  tbcl_result_t expected_results [$];

  logic idle_on;
  logic hold_req;
  logic hold_off;
  int   mismatch_count;
  int   results_seen;
  int   samples_total;
  int   live_items;
  int   unlock_total;
  int   fail_total;
  int   phase_fails;
  int   cycle_count;

  two_button_combination_lock u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .key_zero_level_i (key_zero_level_i),
    .key_one_level_i  (key_one_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .lock_mode_o      (lock_mode_o),
    .key_held_o       (key_held_o),
    .yellow_level_o   (yellow_level_o),
    .bits_entered_o   (bits_entered_o),
    .unlock_pulse_o   (unlock_pulse_o),
    .fail_pulse_o     (fail_pulse_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void switch_mode(input logic [1:0] next_mode);
    zero_shift = '0;
    one_shift  = '0;
    zero_down  = 1'b0;
    one_down   = 1'b0;
    recent_key = 1'b0;
    code_sr    = '0;
    code_len   = '0;
    cur_mode   = next_mode;
  endfunction

  // Shift one sample into a key history; return 1 on a debounced release.
  function automatic logic shift_key(inout logic [DEBOUNCE_SAMPLES-1:0] hist,
                                     inout logic down, input logic sample);
    logic was_down;
    was_down = down;
    hist = {hist[DEBOUNCE_SAMPLES-2:0], sample};
    if (hist == '1) down = 1'b1;
    if (hist == '0) down = 1'b0;
    return was_down && !down;
  endfunction

  function automatic tbcl_result_t lock_step(input logic k0, input logic k1);
    tbcl_result_t r;
    logic         rel0;
    logic         rel1;
    r = '0;
    if (cur_mode == MODE_BLINK) begin
      flash_timer = flash_timer + 1'b1;
      if (flash_timer == half_period) begin
        flash_timer = '0;
        amber       = ~amber;
        flash_count = flash_count + 1'b1;
        if (flash_count == toggle_target) begin
          amber = 1'b0;
          switch_mode(MODE_LOCKED);
        end
      end
    end else begin
      if (k0) recent_key = 1'b0;
      if (k1) recent_key = 1'b1;
      rel0 = shift_key(zero_shift, zero_down, k0);
      rel1 = shift_key(one_shift, one_down, k1);
      if (rel0 || rel1) begin
        code_sr  = {code_sr[CODE_BITS-2:0], recent_key};
        code_len = code_len + 1'b1;
      end
      if (code_len >= CODE_BITS) begin
        if (cur_mode == MODE_PROG) begin
          saved_code = code_sr;
          switch_mode(MODE_LOCKED);
        end else if (code_sr == saved_code) begin
          r.unlock_pulse = 1'b1;
          switch_mode(MODE_PROG);
        end else begin
          r.fail_pulse = 1'b1;
          flash_timer  = '0;
          flash_count  = '0;
          amber        = 1'b1;
          switch_mode(MODE_BLINK);
        end
      end
    end
    r.lock_mode    = cur_mode;
    r.key_held     = zero_down | one_down;
    r.yellow_level = (cur_mode == MODE_BLINK) ? amber : 1'b0;
    r.bits_entered = code_len;
    return r;
  endfunction

  task automatic send_sample(input logic k0, input logic k1, input logic use_typed,
                             input tbcl_result_t typed);
    tbcl_result_t want;
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    key_zero_level_i <= k0;
    key_one_level_i  <= k1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cur_mode != MODE_BLINK) live_items++;
    samples_total++;
    want = lock_step(k0, k1);
    if (want.unlock_pulse) unlock_total++;
    if (want.fail_pulse) begin
      fail_total++;
      phase_fails++;
    end
    expected_results.push_back(use_typed ? typed : want);
  endtask

  task automatic key_run(input logic k0, input logic k1, input int unsigned n);
    repeat (n) send_sample(k0, k1, 1'b0, '0);
  endtask

  // Press key b, then release; bouncy inserts glitches that may break the bit.
  task automatic enter_bit(input logic b, input bit bouncy);
    int unsigned n_down;
    int unsigned n_up;
    logic        both_first;
    n_down     = $urandom_range(9, 6);
    n_up       = $urandom_range(9, 6);
    both_first = !bouncy && $urandom_range(4) == 0;
    for (int unsigned i = 0; i < n_down; i++) begin
      if (bouncy && $urandom_range(4) == 0) key_run(1'b0, 1'b0, 1);
      else if (i == 0 && both_first) key_run(1'b1, 1'b1, 1);
      else key_run(~b, b, 1);
    end
    for (int unsigned i = 0; i < n_up; i++) begin
      if (bouncy && $urandom_range(4) == 0) key_run(~b, b, 1);
      else key_run(1'b0, 1'b0, 1);
    end
  endtask

  task automatic wait_drained;
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Hold off the receiver for a fixed stretch on request.
  initial begin
    hold_req = 1'b0;
    hold_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_off) begin
        hold_off <= 1'b1;
        hold_req <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    end
  end

  initial begin
    tbcl_result_t got;
    tbcl_result_t want;
    out_stall_i    = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.lock_mode    = lock_mode_o;
        got.key_held     = key_held_o;
        got.yellow_level = yellow_level_o;
        got.bits_entered = bits_entered_o;
        got.unlock_pulse = unlock_pulse_o;
        got.fail_pulse   = fail_pulse_o;
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_results.pop_front();
          if (got.lock_mode !== want.lock_mode || got.key_held !== want.key_held ||
              got.yellow_level !== want.yellow_level ||
              got.bits_entered !== want.bits_entered ||
              got.unlock_pulse !== want.unlock_pulse ||
              got.fail_pulse !== want.fail_pulse) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result %0d: expected mode %0d held %b yellow %b bits %0d ",
                        "unlock %b fail %b, got mode %0d held %b yellow %b bits %0d ",
                        "unlock %b fail %b"}, results_seen,
                       want.lock_mode, want.key_held, want.yellow_level,
                       want.bits_entered, want.unlock_pulse, want.fail_pulse,
                       got.lock_mode, got.key_held, got.yellow_level,
                       got.bits_entered, got.unlock_pulse, got.fail_pulse);
          end
        end
      end
      out_stall_i <= hold_off || (idle_on && $urandom_range(99) < 25);
    end
  end

  initial begin
    int          phase_start;
    int          unlock_base;
    int unsigned pick;
    logic        aim_correct;
    logic        bit_val;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    key_zero_level_i = 1'b0;
    key_one_level_i  = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_BLINK_HALF_PERIOD;
    cfg_data_i       = '0;
    idle_on          = 1'b1;
    samples_total    = 0;
    live_items       = 0;
    unlock_total     = 0;
    fail_total       = 0;
    phase_fails      = 0;
    aim_correct      = 1'b0;
    half_period      = HALF_PERIOD_RST;
    toggle_target    = TOGGLE_COUNT_RST;
    saved_code       = '0;
    flash_timer      = '0;
    flash_count      = '0;
    amber            = 1'b0;
    switch_mode(MODE_PROG);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (KEY_SCRIPT[i])
      for (int r = 0; r < KEY_SCRIPT[i].reps; r++)
        send_sample(KEY_SCRIPT[i].k0, KEY_SCRIPT[i].k1,
                    KEY_SCRIPT[i].typed && r == KEY_SCRIPT[i].reps - 1,
                    KEY_SCRIPT[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      // Keep the reset half period in the first phase.
      if (p > 0) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= CFG_BLINK_HALF_PERIOD;
        cfg_data_i  <= PHASE_HALF[p];
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        half_period = PHASE_HALF[p];
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_BLINK_TOGGLE_COUNT;
      cfg_data_i  <= PHASE_TOGGLE[p];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      toggle_target = PHASE_TOGGLE[p][TOG_W-1:0];
      cfg_valid_i <= 1'b0;
      idle_on = (p != 2);
      if (p == 2) hold_req <= 1'b1;
      phase_fails = 0;
      phase_start = live_items;
      unlock_base = unlock_total;
      while (!(phase_fails > 0 && cur_mode != MODE_BLINK) &&
             live_items - phase_start < PHASE_LIVE_CAP) begin
        if (cur_mode == MODE_BLINK) begin
          key_run(1'($urandom_range(1)), 1'($urandom_range(1)), 1);
        end else begin
          pick = $urandom_range(99);
          // Aim once for the stored code in the unlock phase, other codes are random.
          if (code_len == 0)
            aim_correct = cur_mode == MODE_LOCKED && p == UNLOCK_PHASE &&
                          unlock_total == unlock_base;
          if (aim_correct && cur_mode == MODE_LOCKED) begin
            bit_val = saved_code[CODE_BITS-1-code_len];
            enter_bit(bit_val, 1'b0);
          end else begin
            bit_val = 1'($urandom_range(1));
            if (pick < 85) enter_bit(bit_val, pick >= 70);
            else key_run(1'($urandom_range(1)), 1'($urandom_range(1)),
                         $urandom_range(10, 1));
          end
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d button samples, %0d outside blink mode, over %0d blink settings.",
             samples_total, live_items, N_PHASES);
    $display("Codes accepted: %0d, codes rejected: %0d, results checked: %0d.",
             unlock_total, fail_total, results_seen);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tbcl_pkg.sv
sv/tbcl_debounce.sv
sv/tbcl_core.sv
sv/two_button_combination_lock.sv
test/testbench.sv
